[hdl/bspq_pkg.sv]
// Shared types and constants for the bounded stable priority queue.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package bspq_pkg;

    // Storage geometry
    localparam int CAPACITY = 16;
    localparam int IDX_W    = 4;
    localparam int CNT_W    = 5;
    localparam int ID_W     = 16;
    localparam int LVL_W    = 8;

    // Two-slot item queues on both sides of the engine
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;
    localparam logic [QCNT_W-1:0] QUEUE_DEPTH = 2'd2;

    // Operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;
    localparam logic [1:0] OP_PEEK   = 2'd3;

    localparam logic [CNT_W-1:0] RESET_MAX_ENTRIES = 5'd15;

    typedef struct packed {
        logic [1:0]       op;
        logic [ID_W-1:0]  item_id;
        logic [LVL_W-1:0] level;
    } bspq_in_t;

    typedef struct packed {
        logic             ok;
        logic [ID_W-1:0]  head_id;
        logic [LVL_W-1:0] head_level;
        logic             found;
        logic [CNT_W-1:0] count;
        logic             full_res;
    } bspq_out_t;

    // Decoded operation, one bit per kind
    typedef struct packed {
        logic ins;
        logic rem;
        logic find;
        logic peek;
    } bspq_kind_t;

    typedef struct packed {
        bspq_kind_t       kind;
        logic [ID_W-1:0]  item_id;
        logic [LVL_W-1:0] level;
    } bspq_req_t;

    // Engine status seen by the top level
    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] count;
    } bspq_stat_t;

endpackage

[hdl/bspq_front.sv]
// Front end: two-slot request queue that decodes each item's operation.
// Depends on bspq_pkg.
`timescale 1ns / 1ps

module bspq_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  bspq_pkg::bspq_in_t req_in,
    output logic               req_valid,
    output bspq_pkg::bspq_req_t req,
    input  logic               take
);

    bspq_pkg::bspq_req_t                slots_reg [2];
    logic [bspq_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [bspq_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [bspq_pkg::QCNT_W-1:0]        fill_reg, fill_next;
    bspq_pkg::bspq_req_t                decoded;
    logic                               wr_en;
    logic                               rd_en;

    // Classify the incoming operation
    always_comb
    begin
        decoded.kind    = '0;
        decoded.item_id = req_in.item_id;
        decoded.level   = req_in.level;
        case (req_in.op)
            bspq_pkg::OP_INSERT: decoded.kind.ins  = 1'b1;
            bspq_pkg::OP_REMOVE: decoded.kind.rem  = 1'b1;
            bspq_pkg::OP_SEARCH: decoded.kind.find = 1'b1;
            bspq_pkg::OP_PEEK:   decoded.kind.peek = 1'b1;
            default:             decoded.kind.peek = 1'b1;
        endcase
    end

    assign full      = (fill_reg == bspq_pkg::QUEUE_DEPTH);
    assign req_valid = (fill_reg != '0);
    assign req       = slots_reg[rd_ptr_reg];
    assign wr_en     = push && !full;
    assign rd_en     = take && req_valid;

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (wr_en && !rd_en)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Hold the decoded item in its slot
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slots_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

[hdl/bspq_back.sv]
// Back end: sorted entry row and the scan engine that carries out each operation.
// Depends on bspq_pkg.
`timescale 1ns / 1ps

module bspq_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    input  bspq_pkg::bspq_req_t            req,
    output logic                           take,
    input  logic [bspq_pkg::CNT_W-1:0]     max_entries,
    input  logic                           res_space,
    output logic                           res_push,
    output bspq_pkg::bspq_out_t            res,
    output bspq_pkg::bspq_stat_t           stat
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_INSERT = 2'd1;
    localparam logic [1:0] S_SEARCH = 2'd2;

    localparam logic [bspq_pkg::CNT_W-1:0] CAP_CNT = bspq_pkg::CNT_W'(bspq_pkg::CAPACITY);

    logic [1:0]                       state_reg, state_next;
    logic [bspq_pkg::CNT_W-1:0]       idx_reg, idx_next;
    logic [bspq_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [bspq_pkg::ID_W-1:0]        cur_id_reg;
    logic [bspq_pkg::LVL_W-1:0]       cur_lvl_reg;
    logic [bspq_pkg::ID_W-1:0]        ids_reg  [bspq_pkg::CAPACITY];
    logic [bspq_pkg::LVL_W-1:0]       lvls_reg [bspq_pkg::CAPACITY];
    logic [bspq_pkg::CNT_W-1:0]       limit;
    logic [bspq_pkg::CNT_W-1:0]       idx_plus;
    logic [bspq_pkg::IDX_W-1:0]       scan_pos;
    logic [bspq_pkg::ID_W-1:0]        scan_id;
    logic [bspq_pkg::LVL_W-1:0]       scan_lvl;
    logic                             do_insert;
    logic                             do_remove;

    // Clamp the limit to the row size
    assign limit    = (max_entries > CAP_CNT) ? CAP_CNT : max_entries;
    assign idx_plus = idx_reg + bspq_pkg::CNT_W'(1);
    assign scan_pos = idx_reg[bspq_pkg::IDX_W-1:0];
    assign scan_id  = ids_reg[scan_pos];
    assign scan_lvl = lvls_reg[scan_pos];

    assign stat.busy  = (state_reg != S_IDLE);
    assign stat.count = count_reg;

    // Step the engine one entry per cycle
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        take       = 1'b0;
        res_push   = 1'b0;
        do_insert  = 1'b0;
        do_remove  = 1'b0;
        res        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && res_space)
                begin
                    take     = 1'b1;
                    idx_next = '0;
                    if (req.kind.ins)
                    begin
                        if (count_reg < limit)
                        begin
                            state_next = S_INSERT;
                        end
                        else
                        begin
                            res_push = 1'b1;
                        end
                    end
                    else if (req.kind.rem)
                    begin
                        res_push = 1'b1;
                        if (count_reg != '0)
                        begin
                            res.ok         = 1'b1;
                            res.head_id    = ids_reg[0];
                            res.head_level = lvls_reg[0];
                            do_remove      = 1'b1;
                            count_next     = count_reg - bspq_pkg::CNT_W'(1);
                        end
                    end
                    else if (req.kind.find)
                    begin
                        if (count_reg == '0)
                        begin
                            res_push = 1'b1;
                        end
                        else
                        begin
                            state_next = S_SEARCH;
                        end
                    end
                    else
                    begin
                        res_push = 1'b1;
                        if (count_reg != '0)
                        begin
                            res.head_level = lvls_reg[0];
                        end
                    end
                end
            end
            S_INSERT:
            begin
                // Walk past entries of lower or equal level, then open a slot
                if (idx_reg < count_reg && scan_lvl <= cur_lvl_reg)
                begin
                    idx_next = idx_plus;
                end
                else
                begin
                    do_insert  = 1'b1;
                    count_next = count_reg + bspq_pkg::CNT_W'(1);
                    res_push   = 1'b1;
                    res.ok     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SEARCH:
            begin
                if (scan_id == cur_id_reg)
                begin
                    res_push   = 1'b1;
                    res.found  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (idx_plus == count_reg)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_plus;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        res.count    = count_next;
        res.full_res = (count_next >= limit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
        end
    end

    // Latch the operands and shift the entry row
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cur_id_reg  <= req.item_id;
            cur_lvl_reg <= req.level;
        end
        if (do_remove)
        begin
            for (int i = 0; i < bspq_pkg::CAPACITY - 1; i++)
            begin
                ids_reg[i]  <= ids_reg[i + 1];
                lvls_reg[i] <= lvls_reg[i + 1];
            end
        end
        else if (do_insert)
        begin
            for (int i = 1; i < bspq_pkg::CAPACITY; i++)
            begin
                if (bspq_pkg::CNT_W'(i) > idx_reg)
                begin
                    ids_reg[i]  <= ids_reg[i - 1];
                    lvls_reg[i] <= lvls_reg[i - 1];
                end
            end
            ids_reg[scan_pos]  <= cur_id_reg;
            lvls_reg[scan_pos] <= cur_lvl_reg;
        end
    end

endmodule

[hdl/bspq_out.sv]
// Result side: two-slot queue that holds finished results until popped.
// Depends on bspq_pkg.
`timescale 1ns / 1ps

module bspq_out (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_push,
    input  bspq_pkg::bspq_out_t res,
    output logic                res_full,
    output logic                empty,
    input  logic                pop,
    output bspq_pkg::bspq_out_t rsp
);

    bspq_pkg::bspq_out_t             slots_reg [2];
    logic [bspq_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [bspq_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [bspq_pkg::QCNT_W-1:0]     fill_reg, fill_next;
    logic                            wr_en;
    logic                            rd_en;

    assign res_full = (fill_reg == bspq_pkg::QUEUE_DEPTH);
    assign empty    = (fill_reg == '0);
    assign rsp      = slots_reg[rd_ptr_reg];
    assign wr_en    = res_push && !res_full;
    assign rd_en    = pop && !empty;

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (wr_en && !rd_en)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Hold each result in its slot
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slots_reg[wr_ptr_reg] <= res;
        end
    end

endmodule

[hdl/bounded_stable_priority_queue.sv]
// Top level of the bounded stable priority queue: limit register, front queue,
// scan engine and result queue. Depends on bspq_pkg, bspq_front, bspq_back, bspq_out.
`timescale 1ns / 1ps

// Usage
//   Requests enter through push/full with the req struct (op, item_id, level);
//   an item is taken at a clock edge with push high and full low. Results
//   leave through empty/pop on the rsp struct; the oldest result sits on rsp
//   while empty is low and is taken at an edge with pop high.
//   cfg_we/cfg_wdata write max_entries (reset 15, values above 16 act as 16);
//   write it only while no request is in flight.
//   Remove, peek, a refused insert and a search of an empty queue have their
//   result pushed to the result queue as the engine takes them. An insert
//   first walks past the held entries of lower or equal level (at most 15);
//   a search walks up to the first match or to the last held entry.
//   The scan engine steps one entry per cycle and works on one item at a
//   time, so it takes no new item until the result of the last is pushed.
//   Two requests can wait in the front queue and two results in the result
//   queue; when the receiver stalls the engine stops taking items once the
//   result queue is full, and full rises when the front queue fills.
//   Reset empties both queues and the queue itself and restores the limit.
module bounded_stable_priority_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  bspq_pkg::bspq_in_t         req,
    output logic                       empty,
    input  logic                       pop,
    output bspq_pkg::bspq_out_t        rsp,
    input  logic                       cfg_we,
    input  logic [bspq_pkg::CNT_W-1:0] cfg_wdata
);

    logic [bspq_pkg::CNT_W-1:0] max_entries_reg, max_entries_next;
    logic                       req_valid;
    bspq_pkg::bspq_req_t        req_dec;
    logic                       take;
    logic                       res_push;
    bspq_pkg::bspq_out_t        res;
    logic                       res_full;
    bspq_pkg::bspq_stat_t       stat;

    // Limit register
    assign max_entries_next = cfg_we ? cfg_wdata : max_entries_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= bspq_pkg::RESET_MAX_ENTRIES;
        end
        else
        begin
            max_entries_reg <= max_entries_next;
        end
    end

    bspq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req_in    (req),
        .req_valid (req_valid),
        .req       (req_dec),
        .take      (take)
    );

    bspq_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req         (req_dec),
        .take        (take),
        .max_entries (max_entries_reg),
        .res_space   (!res_full),
        .res_push    (res_push),
        .res         (res),
        .stat        (stat)
    );

    bspq_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res      (res),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .rsp      (rsp)
    );

    // The held count never exceeds the row size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.count <= bspq_pkg::CNT_W'(bspq_pkg::CAPACITY))
        else $error("entry count above capacity");

    // A result is only produced when the result queue has room
    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full result queue");

    // The engine takes a new item only when idle
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> !stat.busy)
        else $error("item taken while engine busy");

    // The count moves by at most one per cycle
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (stat.count == $past(stat.count)
            || stat.count == $past(stat.count) + bspq_pkg::CNT_W'(1)
            || stat.count == $past(stat.count) - bspq_pkg::CNT_W'(1)))
        else $error("entry count jumped");

endmodule
